@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ rtl/stcg_pkg.sv @@
package stcg_pkg;

  // reciprocal zoom and accumulator widths
  localparam int unsigned ZoomW      = 24;
  localparam int unsigned QuotW      = 23;
  localparam int unsigned DivW       = 14;
  localparam int unsigned AccW       = 27;
  localparam int unsigned ScaleShift = 12;
  localparam int unsigned SpanShift  = 13;

  // config port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // job queue depth
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FLIP_X   = 3'd0,
    REG_FLIP_Y   = 3'd1,
    REG_SCROLL_X = 3'd2,
    REG_SCROLL_Y = 3'd3,
    REG_BOARD_DX = 3'd4,
    REG_BOARD_DY = 3'd5,
    REG_REJECTED = 3'd6
  } cfg_reg_e;

  localparam logic [15:0]      ZoomLimit   = 16'h2000;
  localparam logic [ZoomW-1:0] ZoomZero    = 24'h800000;
  localparam logic [ZoomW-1:0] ZoomUnity   = 24'h010000;
  localparam logic [QuotW-1:0] RecipNum    = 23'h400000;
  localparam logic [15:0]      XBias       = 16'h005d;
  localparam logic [15:0]      YBias       = 16'h0007;
  localparam logic [15:0]      FlipXOrigin = 16'd512;
  localparam logic [9:0]       XWrap       = 10'd768;
  localparam logic [9:0]       YWrap       = 10'd640;
  localparam logic [AccW-1:0]  RoundHalf   = 27'd2048;

  // reciprocal unit status
  typedef struct packed {
    logic busy;
    logic done;
  } recip_st_t;

  // one classified sprite, handed from front to back
  typedef struct packed {
    logic [15:0]      code;
    logic [7:0]       colour;
    logic             shadow;
    logic             zoomed;
    logic             mir_x;
    logic             mir_y;
    logic             flip_x;
    logic             flip_y;
    logic [1:0]       size_x;
    logic [1:0]       size_y;
    logic [ZoomW-1:0] zoom_x;
    logic [ZoomW-1:0] zoom_y;
    logic [15:0]      org_x;
    logic [15:0]      org_y;
  } job_t;

endpackage

@@ rtl/stcg_if.sv @@
interface stcg_cfg_if;
  import stcg_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface stcg_item_if;
  logic        valid;
  logic        ready;
  logic [6:0]  entry_index;
  logic [15:0] attr_word;
  logic [15:0] code_word;
  logic [15:0] ypos_word;
  logic [15:0] xpos_word;
  logic [15:0] zoomy_word;
  logic [15:0] zoomx_word;
  logic [15:0] colour_word;

  modport source (
    output valid, output entry_index, output attr_word, output code_word,
    output ypos_word, output xpos_word, output zoomy_word, output zoomx_word,
    output colour_word, input ready
  );
  modport sink (
    input valid, input entry_index, input attr_word, input code_word,
    input ypos_word, input xpos_word, input zoomy_word, input zoomx_word,
    input colour_word, output ready
  );
endinterface

interface stcg_tile_if;
  logic        valid;
  logic        ready;
  logic [15:0] tile_code;
  logic [7:0]  colour;
  logic        tile_flip_x;
  logic        tile_flip_y;
  logic [15:0] screen_x;
  logic [15:0] screen_y;
  logic [11:0] tile_width;
  logic [11:0] tile_height;
  logic        shadow;
  logic        zoomed;
  logic        last;

  modport source (
    output valid, output tile_code, output colour, output tile_flip_x,
    output tile_flip_y, output screen_x, output screen_y, output tile_width,
    output tile_height, output shadow, output zoomed, output last, input ready
  );
  modport sink (
    input valid, input tile_code, input colour, input tile_flip_x,
    input tile_flip_y, input screen_x, input screen_y, input tile_width,
    input tile_height, input shadow, input zoomed, input last, output ready
  );
endinterface

@@ rtl/stcg_recip.sv @@
module stcg_recip (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [stcg_pkg::DivW-1:0] zoom_i,
  output stcg_pkg::recip_st_t      status_o,
  output logic [stcg_pkg::ZoomW-1:0] recip_o
);
  import stcg_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [QuotW-1:0] num_q;
  logic [DivW-1:0]  rem_q;
  logic [DivW-1:0]  div_q;
  logic [ZoomW-1:0] res_q;

  logic [DivW:0]    trial;
  logic             q_bit;
  logic [DivW:0]    trial_sub;
  logic [QuotW-1:0] num_d;

  // restoring division, one quotient bit per cycle
  assign trial     = {rem_q, num_q[QuotW-1]};
  assign q_bit     = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};
  assign num_d     = {num_q[QuotW-2:0], q_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (zoom_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(QuotW - 1);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // numerator carries the rounding half of the divisor
      num_q <= RecipNum + {{(QuotW-DivW+1){1'b0}}, zoom_i[DivW-1:1]};
      div_q <= zoom_i;
      rem_q <= '0;
      if (zoom_i == '0) begin
        res_q <= ZoomZero;
      end
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= q_bit ? trial_sub[DivW-1:0] : trial[DivW-1:0];
      if (cnt_q == '0) begin
        res_q <= {{(ZoomW-QuotW){1'b0}}, num_d};
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign recip_o       = res_q;

endmodule

@@ rtl/stcg_front.sv @@
`include "assert_macros.svh"

module stcg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  stcg_cfg_if.sink            cfg_i,
  stcg_item_if.sink           item_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output stcg_pkg::job_t      job_o
);
  import stcg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT_Y,
    S_WAIT_X,
    S_PUSH
  } state_e;

  state_e state_q;

  // config registers
  logic        scr_flip_x_q;
  logic        scr_flip_y_q;
  logic [15:0] scroll_x_q;
  logic [15:0] scroll_y_q;
  logic [9:0]  board_dx_q;
  logic [9:0]  board_dy_q;
  logic [7:0]  rejected_q;

  // sprite held while the reciprocals are formed
  logic [DivW-1:0]  zx_word_q;
  logic             aspect_q;
  logic [3:0]       size_q;
  logic [15:0]      code_q;
  logic [7:0]       colour_q;
  logic             shadow_q;
  logic             mir_x_q;
  logic             mir_y_q;
  logic             flip_x_q;
  logic             flip_y_q;
  logic [15:0]      org_x_q;
  logic [15:0]      org_y_q;
  logic [ZoomW-1:0] zoom_x_q;
  logic [ZoomW-1:0] zoom_y_q;

  logic accept;
  logic keep;
  logic recip_start;
  logic [DivW-1:0]  recip_zoom;
  recip_st_t        recip_st;
  logic [ZoomW-1:0] recip_val;

  logic [15:0] ox_a;
  logic [15:0] ox_b;
  logic [15:0] ox_c;
  logic [15:0] oy_a;
  logic [15:0] oy_b;
  logic [15:0] oy_c;
  logic [15:0] org_x_d;
  logic [15:0] org_y_d;
  logic        mir_x_d;
  logic        mir_y_d;
  logic        flip_x_d;
  logic        flip_y_d;
  logic [15:0] code_d;
  logic [AccW-1:0] span_x;
  logic [AccW-1:0] span_y;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_flip_x_q <= 1'b0;
      scr_flip_y_q <= 1'b0;
      scroll_x_q   <= '0;
      scroll_y_q   <= '0;
      board_dx_q   <= '0;
      board_dy_q   <= '0;
      rejected_q   <= 8'hff;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FLIP_X:   scr_flip_x_q <= cfg_i.data[0];
        REG_FLIP_Y:   scr_flip_y_q <= cfg_i.data[0];
        REG_SCROLL_X: scroll_x_q   <= cfg_i.data;
        REG_SCROLL_Y: scroll_y_q   <= cfg_i.data;
        REG_BOARD_DX: board_dx_q   <= cfg_i.data[9:0];
        REG_BOARD_DY: board_dy_q   <= cfg_i.data[9:0];
        REG_REJECTED: rejected_q   <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;

  // drop rules: inactive, rejected priority on nonzero index, oversized zoom
  assign keep = item_i.attr_word[15]
             && !((item_i.entry_index != '0)
                  && ({1'b0, item_i.attr_word[6:0]} == rejected_q))
             && (item_i.zoomy_word <= ZoomLimit)
             && (item_i.attr_word[14] || (item_i.zoomx_word <= ZoomLimit));

  // tile code bits 4:1 come in scrambled
  assign code_d = {item_i.code_word[15:5], item_i.code_word[3], item_i.code_word[1],
                   item_i.code_word[4], item_i.code_word[2], item_i.code_word[0]};

  assign mir_x_d  = item_i.colour_word[8];
  assign mir_y_d  = item_i.colour_word[9];
  assign flip_x_d = mir_x_d ? 1'b0 : (item_i.attr_word[12] ^ scr_flip_x_q);
  assign flip_y_d = item_i.attr_word[13] ^ (scr_flip_y_q && !mir_y_d);

  // centre placement, kept to a 10 bit window
  assign ox_a = item_i.xpos_word + scroll_x_q + {{6{board_dx_q[9]}}, board_dx_q};
  assign ox_b = scr_flip_x_q ? (FlipXOrigin - ox_a) : ox_a;
  assign ox_c = ox_b + XBias;
  assign org_x_d = (ox_c[9:0] >= XWrap) ? {6'h3f, ox_c[9:0]} : {6'h00, ox_c[9:0]};

  assign oy_a = item_i.ypos_word + {{6{board_dy_q[9]}}, board_dy_q};
  assign oy_b = scr_flip_y_q ? (16'd0 - oy_a) : oy_a;
  assign oy_c = 16'd0 - (oy_b + scroll_y_q + YBias);
  assign org_y_d = (oy_c[9:0] >= YWrap) ? {6'h3f, oy_c[9:0]} : {6'h00, oy_c[9:0]};

  assign recip_start = (accept && keep)
                    || ((state_q == S_WAIT_Y) && recip_st.done && !aspect_q);
  assign recip_zoom  = (state_q == S_IDLE) ? item_i.zoomy_word[DivW-1:0] : zx_word_q;

  stcg_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (recip_start),
    .zoom_i   (recip_zoom),
    .status_o (recip_st),
    .recip_o  (recip_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && keep) begin
            state_q   <= S_WAIT_Y;
            zx_word_q <= item_i.zoomx_word[DivW-1:0];
            aspect_q  <= item_i.attr_word[14];
            size_q    <= item_i.attr_word[11:8];
            code_q    <= code_d;
            colour_q  <= item_i.colour_word[7:0];
            shadow_q  <= item_i.colour_word[7];
            mir_x_q   <= mir_x_d;
            mir_y_q   <= mir_y_d;
            flip_x_q  <= flip_x_d;
            flip_y_q  <= flip_y_d;
            org_x_q   <= org_x_d;
            org_y_q   <= org_y_d;
          end
        end
        S_WAIT_Y: begin
          if (recip_st.done) begin
            zoom_y_q <= recip_val;
            if (aspect_q) begin
              zoom_x_q <= recip_val;
              state_q  <= S_PUSH;
            end else begin
              state_q  <= S_WAIT_X;
            end
          end
        end
        S_WAIT_X: begin
          if (recip_st.done) begin
            zoom_x_q <= recip_val;
            state_q  <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (job_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // origin moves back by half the scaled sprite size
  assign span_x = {{(AccW-ZoomW){1'b0}}, zoom_x_q} << size_q[1:0];
  assign span_y = {{(AccW-ZoomW){1'b0}}, zoom_y_q} << size_q[3:2];

  assign job_valid_o   = (state_q == S_PUSH);
  assign job_o.code    = code_q;
  assign job_o.colour  = colour_q;
  assign job_o.shadow  = shadow_q;
  assign job_o.zoomed  = !((zoom_x_q == ZoomUnity) && (zoom_y_q == ZoomUnity));
  assign job_o.mir_x   = mir_x_q;
  assign job_o.mir_y   = mir_y_q;
  assign job_o.flip_x  = flip_x_q;
  assign job_o.flip_y  = flip_y_q;
  assign job_o.size_x  = size_q[1:0];
  assign job_o.size_y  = size_q[3:2];
  assign job_o.zoom_x  = zoom_x_q;
  assign job_o.zoom_y  = zoom_y_q;
  assign job_o.org_x   = org_x_q
                       - {{(16-(AccW-SpanShift)){1'b0}}, span_x[AccW-1:SpanShift]};
  assign job_o.org_y   = org_y_q
                       - {{(16-(AccW-SpanShift)){1'b0}}, span_y[AccW-1:SpanShift]};

  `ASSERT_NEVER(a_recip_restart, clk_i, rst_ni, recip_start && recip_st.busy)
  `ASSERT_AT(a_push_holds, clk_i, rst_ni,
             (state_q == S_PUSH && !job_ready_i) |=> (state_q == S_PUSH))

endmodule

@@ rtl/stcg_fifo.sv @@
`include "assert_macros.svh"

module stcg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stcg_pkg::job_t push_data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output stcg_pkg::job_t pop_data_o
);
  import stcg_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  job_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic do_push;
  logic do_pop;

  assign ready_o    = (count_q != CntW'(FifoDepth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // a full queue holds its count, the front simply waits
  `ASSERT_AT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(FifoDepth))
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o)

endmodule

@@ rtl/stcg_back.sv @@
`include "assert_macros.svh"

module stcg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  stcg_pkg::job_t job_i,
  output logic           job_pop_o,
  stcg_tile_if.source    tile_o
);
  import stcg_pkg::*;

  logic            busy_q;
  job_t            job_q;
  logic [2:0]      x_q;
  logic [2:0]      y_q;
  logic [AccW-1:0] acc_x_q;
  logic [AccW-1:0] acc_y_q;

  logic            out_valid_q;
  logic [15:0]     code_q;
  logic [7:0]      colour_q;
  logic            fx_q;
  logic            fy_q;
  logic [15:0]     sx_q;
  logic [15:0]     sy_q;
  logic [11:0]     w_q;
  logic [11:0]     h_q;
  logic            shadow_q;
  logic            zoomed_q;
  logic            last_q;

  logic            advance;
  logic            load;
  logic [3:0]      w_cnt;
  logic [3:0]      h_cnt;
  logic [2:0]      w_mask;
  logic [2:0]      h_mask;
  logic            last_col;
  logic            last_row;
  logic [AccW-1:0] nacc_x;
  logic [AccW-1:0] nacc_y;
  logic [AccW-ScaleShift-1:0] size_x_px;
  logic [AccW-ScaleShift-1:0] size_y_px;
  logic            mcond_x;
  logic            mcond_y;
  logic [2:0]      col;
  logic [2:0]      row;
  logic            fx;
  logic            fy;
  logic [5:0]      c6;

  assign w_cnt    = 4'b0001 << job_q.size_x;
  assign h_cnt    = 4'b0001 << job_q.size_y;
  assign w_mask   = w_cnt[2:0] - 3'd1;
  assign h_mask   = h_cnt[2:0] - 3'd1;
  assign last_col = (x_q == w_mask);
  assign last_row = (y_q == h_mask);

  assign advance   = busy_q && (!out_valid_q || tile_o.ready);
  assign load      = job_valid_i && (!busy_q || (advance && last_col && last_row));
  assign job_pop_o = load;

  // accumulators hold zoom times index plus the rounding half
  assign nacc_x    = acc_x_q + {{(AccW-ZoomW){1'b0}}, job_q.zoom_x};
  assign nacc_y    = acc_y_q + {{(AccW-ZoomW){1'b0}}, job_q.zoom_y};
  assign size_x_px = nacc_x[AccW-1:ScaleShift] - acc_x_q[AccW-1:ScaleShift];
  assign size_y_px = nacc_y[AccW-1:ScaleShift] - acc_y_q[AccW-1:ScaleShift];

  // mirrored sprites fold about their centre
  assign mcond_x = (!job_q.flip_x) ^ ({x_q, 1'b0} < w_cnt);
  assign mcond_y = (!job_q.flip_y) ^ ({y_q, 1'b0} >= h_cnt);

  always_comb begin
    if (job_q.mir_x) begin
      col = mcond_x ? (w_mask - x_q) : x_q;
      fx  = mcond_x;
    end else begin
      col = job_q.flip_x ? (w_mask - x_q) : x_q;
      fx  = job_q.flip_x;
    end
    if (job_q.mir_y) begin
      row = mcond_y ? (h_mask - y_q) : y_q;
      fy  = mcond_y;
    end else begin
      row = job_q.flip_y ? (h_mask - y_q) : y_q;
      fy  = job_q.flip_y;
    end
  end

  assign c6 = job_q.code[5:0] + {3'b000, col} + {row, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (advance && last_col && last_row) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q   <= job_i;
      x_q     <= '0;
      y_q     <= '0;
      acc_x_q <= RoundHalf;
      acc_y_q <= RoundHalf;
    end else if (advance) begin
      if (last_col) begin
        x_q     <= '0;
        acc_x_q <= RoundHalf;
        y_q     <= y_q + 1'b1;
        acc_y_q <= nacc_y;
      end else begin
        x_q     <= x_q + 1'b1;
        acc_x_q <= nacc_x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (tile_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q   <= {job_q.code[15:6], c6};
      colour_q <= job_q.colour;
      fx_q     <= fx;
      fy_q     <= fy;
      sx_q     <= job_q.org_x + {1'b0, acc_x_q[AccW-1:ScaleShift]};
      sy_q     <= job_q.org_y + {1'b0, acc_y_q[AccW-1:ScaleShift]};
      w_q      <= size_x_px[11:0];
      h_q      <= size_y_px[11:0];
      shadow_q <= job_q.shadow;
      zoomed_q <= job_q.zoomed;
      last_q   <= last_col && last_row;
    end
  end

  assign tile_o.valid       = out_valid_q;
  assign tile_o.tile_code   = code_q;
  assign tile_o.colour      = colour_q;
  assign tile_o.tile_flip_x = fx_q;
  assign tile_o.tile_flip_y = fy_q;
  assign tile_o.screen_x    = sx_q;
  assign tile_o.screen_y    = sy_q;
  assign tile_o.tile_width  = w_q;
  assign tile_o.tile_height = h_q;
  assign tile_o.shadow      = shadow_q;
  assign tile_o.zoomed      = zoomed_q;
  assign tile_o.last        = last_q;

  `ASSERT_AT(a_col_in_range, clk_i, rst_ni, busy_q |-> (x_q <= w_mask))
  `ASSERT_AT(a_row_in_range, clk_i, rst_ni, busy_q |-> (y_q <= h_mask))

endmodule

@@ rtl/sprite_tile_command_generator_top.sv @@
// a kept record has zoom y turned into a reciprocal after accept, then zoom x unless the
// aspect bit shares zoom y; a zero zoom gives its reciprocal without a division
// the front takes a new record only after the last is pushed, its pace set by the shared
// bit-serial reciprocal divider; the back emits one tile a cycle while jobs are queued
// and the sink is ready, 1 to 64 per record; dropped records are taken in idle, no tiles
// reset: config registers go to their reset values, job queue and tile output empty
module sprite_tile_command_generator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  stcg_cfg_if.sink   cfg_i,
  stcg_item_if.sink  item_i,
  stcg_tile_if.source tile_o
);
  import stcg_pkg::*;

  // front to queue
  logic job_push;
  logic job_push_ready;
  job_t job_in;

  // queue to back
  logic job_avail;
  logic job_pop;
  job_t job_out;

  // front: config registers, drop checks, code unscramble, reciprocal zooms and
  // sprite origin; one record in flight while the divider runs
  stcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .item_i      (item_i),
    .job_valid_o (job_push),
    .job_ready_i (job_push_ready),
    .job_o       (job_in)
  );

  // short job queue so the front can start the next record while the back
  // is still walking the tiles of the previous one
  stcg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .ready_o     (job_push_ready),
    .pop_i       (job_pop),
    .valid_o     (job_avail),
    .pop_data_o  (job_out)
  );

  // back: rows outer, columns inner, running zoom accumulators for position
  // and scaled size, registered tile beat toward the sink
  stcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_avail),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .tile_o      (tile_o)
  );

endmodule
